// ----- design/twl_pkg.sv -----
// Shared types and constants for the tetrahedral walk locator.
// No dependencies.
package twl_pkg;

    localparam logic [2:0] MODE_PROBE = 3'd0;
    localparam logic [2:0] MODE_VERT  = 3'd1;
    localparam logic [2:0] MODE_NBR   = 3'd2;
    localparam logic [2:0] MODE_ROW   = 3'd3;
    localparam logic [2:0] MODE_QUERY = 3'd4;

    localparam logic [1:0] OUT_INSIDE   = 2'd0;
    localparam logic [1:0] OUT_OUTSIDE  = 2'd1;
    localparam logic [1:0] OUT_PINGPONG = 2'd2;
    localparam logic [1:0] OUT_LIMIT    = 2'd3;

    localparam logic       REG_COUNT = 1'b0;
    localparam logic       REG_TOL   = 1'b1;

    // exact weight: three 53-bit terms plus 1.0 need 55 bits
    typedef logic signed [55:0] t_wgt;

    localparam logic signed [28:0] TOL_RESET = -29'sd2684;
    localparam t_wgt               ONE_Q28   = 56'sd268435456;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_RD_TET,
        S_RD_POS,
        S_DIFF,
        S_MUL,
        S_ACC,
        S_EVAL,
        S_DONE,
        S_OUT
    } t_state;

    // one weight product: d (33b) * coeff (32b), floor-shifted by 12
    typedef struct packed {
        logic signed [32:0] d;
        logic signed [31:0] c;
    } t_mul_in;

    function automatic logic signed [31:0] sat32(input t_wgt v);
        t_wgt hi;
        t_wgt lo;
        hi = 56'sd2147483647;
        lo = -56'sd2147483648;
        if (v > hi) begin
            sat32 = 32'sh7fffffff;
        end else if (v < lo) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    // coefficient k of the row-major 3x3 matrix: column it multiplies
    function automatic logic [1:0] coef_col(input logic [3:0] k);
        case (k) inside
            4'd0, 4'd3, 4'd6: coef_col = 2'd0;
            4'd1, 4'd4, 4'd7: coef_col = 2'd1;
            default:          coef_col = 2'd2;
        endcase
    endfunction

    // coefficient k: weight slot (row + 1) it adds into
    function automatic logic [1:0] wgt_slot(input logic [3:0] k);
        case (k) inside
            [4'd0:4'd2]: wgt_slot = 2'd1;
            [4'd3:4'd5]: wgt_slot = 2'd2;
            default:     wgt_slot = 2'd3;
        endcase
    endfunction

endpackage

// ----- design/twl_ram.sv -----
// Generic single-port-write, single-port-read synchronous RAM.
// Registered read. No dependencies.
module twl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/twl_mac.sv -----
// Registered weight product unit: one 33x32 multiply, floor shift by 12.
// Depends on twl_pkg.
module twl_mac import twl_pkg::*; (
    input  logic                 i_clk,
    input  t_mul_in              i_op,
    output logic signed [52:0]   o_term
);
    logic signed [64:0] prod;
    logic signed [52:0] r_term;

    assign prod = 65'(i_op.d) * 65'(i_op.c);

    always_ff @(posedge i_clk) begin
        r_term <= prod[64:12];
    end

    assign o_term = r_term;
endmodule

// ----- design/tetrahedral_walk_locate.sv -----
// Tetrahedral mesh point-location walk, top level.
// Depends on twl_pkg, twl_ram, twl_mac.
//
// Input channel (i_valid/o_stall) carries loads (modes 0-3, 5-7) and queries
// (mode 4). Loads write the probe and tetrahedron memories and give no result.
// A query walks tetrahedra from the remembered hint and gives one result on
// the output channel (o_valid/i_stall) with outcome, tetrahedron and weights.
// Probe, vertex, neighbour and unused-mode loads finish sooner than a matrix
// row load, which makes three coefficient writes. Each walk pass reads the
// tetrahedron, reads the vertex-0 position, forms the difference, runs nine
// products through one shared registered multiplier, then sums and evaluates.
// o_valid rises after n walk passes, n at most count+2 with count =
// min(tet_count, TET_DEPTH) (count+1 steps plus one final weight pass at
// the step limit); an empty mesh answers without a walk pass.
// The multiplier and the single read port per memory set the pass time.
// One item is in work at a time; o_stall is high from acceptance until the
// block is idle again. A stalled result holds on the outputs; the next
// transfer can be accepted in the cycle after the result is taken.
// Reset clears the state machine, the hint and the registers (tet_count 0,
// inside_tolerance -2684); memory contents are undefined until written.
// Configuration is written by APB; registers at byte 0 and 4.
module tetrahedral_walk_locate import twl_pkg::*; #(
    parameter int TET_DEPTH   = 1024,
    parameter int PROBE_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_mode,
    input  logic [9:0]         i_entry_index,
    input  logic [1:0]         i_row_select,
    input  logic signed [31:0] i_val_x,
    input  logic signed [31:0] i_val_y,
    input  logic signed [31:0] i_val_z,
    input  logic signed [10:0] i_slot0,
    input  logic signed [10:0] i_slot1,
    input  logic signed [10:0] i_slot2,
    input  logic signed [10:0] i_slot3,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_outcome,
    output logic [9:0]         o_tet_index,
    output logic signed [31:0] o_weight0,
    output logic signed [31:0] o_weight1,
    output logic signed [31:0] o_weight2,
    output logic signed [31:0] o_weight3,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    localparam int TW = (TET_DEPTH > 1) ? $clog2(TET_DEPTH) : 1;
    localparam int PW = $clog2(PROBE_DEPTH);
    localparam int CW = $clog2(TET_DEPTH*9);

    // configuration
    logic [10:0]        r_tet_count;
    logic signed [28:0] r_tol;
    logic               cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tet_count <= 11'd0;
            r_tol       <= TOL_RESET;
        end else if (cfg_wr && paddr[2:2] == REG_COUNT && paddr[1:0] == 2'd0) begin
            r_tet_count <= pwdata[10:0];
        end else if (cfg_wr && paddr[2:2] == REG_TOL && paddr[1:0] == 2'd0) begin
            r_tol <= pwdata[28:0];
        end
    end
    always_comb begin
        prdata = 32'd0;
        if (paddr == 3'd0) prdata = {21'd0, r_tet_count};
        else if (paddr == 3'd4) prdata = {{3{r_tol[28]}}, r_tol};
    end

    // effective count, min(tet_count, TET_DEPTH), 17 bits covers 65536
    logic [16:0] count;
    assign count = (17'(r_tet_count) > 17'(TET_DEPTH)) ? 17'(TET_DEPTH)
                                                      : 17'(r_tet_count);

    // captured item
    logic [2:0]         r_mode;
    logic [9:0]         r_idx;
    logic [1:0]         r_row;
    logic signed [31:0] r_vx, r_vy, r_vz;
    logic [43:0]        r_slots;

    t_state r_state, n_state;
    logic   acc;
    assign acc = i_valid && !o_stall;

    // walk state
    logic [TW-1:0]      r_cur, r_prev;
    logic               r_has_prev;
    logic [16:0]        r_steps;
    logic [3:0]         r_k;
    logic               r_final;
    logic [9:0]         r_hint;
    logic signed [32:0] r_d [3];
    t_wgt               r_w [4];
    logic [1:0]         r_outc;
    logic [43:0]        r_nbr;

    // memories
    logic        we_pos, we_vert, we_nbr, we_co;
    logic [PW-1:0] pos_waddr, pos_raddr;
    logic [TW-1:0] tet_waddr;
    logic [CW-1:0] co_waddr, co_raddr;
    logic [31:0] px_q, py_q, pz_q, co_q;
    logic [39:0] vert_q;
    logic [43:0] nbr_q;
    logic [1:0]  co_sub;

    assign pos_waddr = PW'(r_idx);
    assign tet_waddr = TW'(r_idx);
    assign we_pos  = r_state == S_START && r_mode == MODE_PROBE
                     && 17'(r_idx) < 17'(PROBE_DEPTH);
    assign we_vert = r_state == S_START && r_mode == MODE_VERT
                     && 17'(r_idx) < 17'(TET_DEPTH);
    assign we_nbr  = r_state == S_START && r_mode == MODE_NBR
                     && 17'(r_idx) < 17'(TET_DEPTH);
    // vertex 0 straight from the tetrahedron read, valid in S_RD_POS
    assign pos_raddr = PW'(vert_q[9:0]);
    assign co_raddr  = CW'(r_cur) * CW'(9) + CW'(r_k);

    twl_ram #(.WIDTH(32), .DEPTH(PROBE_DEPTH)) u_px (.i_clk, .i_we(we_pos),
        .i_waddr(pos_waddr), .i_wdata(r_vx), .i_raddr(pos_raddr), .o_rdata(px_q));
    twl_ram #(.WIDTH(32), .DEPTH(PROBE_DEPTH)) u_py (.i_clk, .i_we(we_pos),
        .i_waddr(pos_waddr), .i_wdata(r_vy), .i_raddr(pos_raddr), .o_rdata(py_q));
    twl_ram #(.WIDTH(32), .DEPTH(PROBE_DEPTH)) u_pz (.i_clk, .i_we(we_pos),
        .i_waddr(pos_waddr), .i_wdata(r_vz), .i_raddr(pos_raddr), .o_rdata(pz_q));
    twl_ram #(.WIDTH(40), .DEPTH(TET_DEPTH)) u_vert (.i_clk, .i_we(we_vert),
        .i_waddr(tet_waddr), .i_wdata(r_slots[39:0]), .i_raddr(r_cur),
        .o_rdata(vert_q));
    twl_ram #(.WIDTH(44), .DEPTH(TET_DEPTH)) u_nbr (.i_clk, .i_we(we_nbr),
        .i_waddr(tet_waddr), .i_wdata(r_slots), .i_raddr(r_cur), .o_rdata(nbr_q));
    twl_ram #(.WIDTH(32), .DEPTH(TET_DEPTH*9)) u_co (.i_clk, .i_we(we_co),
        .i_waddr(co_waddr), .i_wdata(co_sub == 2'd0 ? r_vx :
                                     co_sub == 2'd1 ? r_vy : r_vz),
        .i_raddr(co_raddr), .o_rdata(co_q));

    // matrix row load: three writes, one per S_START/S_RD_TET/S_RD_POS cycle
    assign co_sub   = (r_state == S_START) ? 2'd0 : (r_state == S_RD_TET) ? 2'd1 : 2'd2;
    assign co_waddr = CW'(r_idx) * CW'(9) + CW'(r_row) * CW'(3) + CW'(co_sub);
    assign we_co    = r_mode == MODE_ROW && r_row != 2'd3 && 17'(r_idx) < 17'(TET_DEPTH)
                      && (r_state == S_START || r_state == S_RD_TET || r_state == S_RD_POS)
                      && !r_final;

    // multiplier: coefficient k arrives the cycle after r_k = k is issued
    logic [3:0]         r_kq;
    logic               r_kv;
    logic [3:0]         r_kt;
    logic               r_tv;
    t_mul_in            mop;
    logic signed [52:0] term;
    assign mop.d = r_d[coef_col(r_kq)];
    assign mop.c = co_q;
    twl_mac u_mac (.i_clk, .i_op(mop), .o_term(term));

    // evaluation
    t_wgt               tol_w;
    logic               all_in;
    logic [1:0]         f;
    t_wgt               worst;
    logic signed [10:0] nb;
    assign tol_w = 56'(r_tol);
    assign all_in = r_w[0] >= tol_w && r_w[1] >= tol_w
                    && r_w[2] >= tol_w && r_w[3] >= tol_w;
    always_comb begin
        f = 2'd0;
        worst = r_w[0];
        for (int k = 1; k < 4; k++) begin
            if (r_w[k] < worst) begin
                worst = r_w[k];
                f = 2'(k);
            end
        end
    end
    assign nb = r_nbr[11*f +: 11];

    logic bad_nb, pingpong, limit;
    assign bad_nb   = nb[10] || 17'(nb[9:0]) >= count;
    assign pingpong = r_has_prev && TW'(nb[9:0]) == r_prev;
    assign limit    = r_steps + 17'd1 >= count + 17'd1;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (acc) n_state = S_START;
            S_START: begin
                if (r_mode == MODE_QUERY) begin
                    n_state = (count == 17'd0) ? S_DONE : S_RD_TET;
                end else if (r_mode == MODE_ROW) begin
                    n_state = S_RD_TET;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RD_TET: n_state = (r_mode == MODE_ROW) ? S_RD_POS : S_RD_POS;
            S_RD_POS: n_state = (r_mode == MODE_ROW) ? S_IDLE : S_DIFF;
            S_DIFF:   n_state = S_MUL;
            S_MUL:    if (r_tv && r_kt == 4'd8) n_state = S_ACC;
            S_ACC:    n_state = S_EVAL;
            S_EVAL: begin
                // at the step limit one more pass recomputes the weights
                if (r_final || all_in || bad_nb || pingpong) n_state = S_DONE;
                else n_state = S_RD_TET;
            end
            S_DONE: n_state = S_OUT;
            S_OUT:  if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_stall = r_state != S_IDLE;
        o_valid = r_state == S_OUT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hint  <= 10'd0;
            r_kv    <= 1'b0;
            r_tv    <= 1'b0;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kv <= r_state == S_MUL && r_k != 4'd9;
            r_tv <= r_kv;
            if (r_state == S_IDLE) r_final <= 1'b0;
            if (r_state == S_EVAL && !r_final && !all_in && !bad_nb && !pingpong
                && limit) begin
                r_final <= 1'b1;
            end
            if (r_state == S_DONE && r_outc != OUT_OUTSIDE) r_hint <= 10'(r_cur);
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_mode  <= i_mode;
            r_idx   <= i_entry_index;
            r_row   <= i_row_select;
            r_vx    <= i_val_x;
            r_vy    <= i_val_y;
            r_vz    <= i_val_z;
            r_slots <= {i_slot3, i_slot2, i_slot1, i_slot0};
        end
        r_kq <= r_k;
        r_kt <= r_kq;
        case (r_state)
            S_START: begin
                r_cur      <= (17'(r_hint) < count) ? TW'(r_hint) : TW'(0);
                r_has_prev <= 1'b0;
                r_steps    <= 17'd0;
                r_outc     <= (count == 17'd0) ? OUT_OUTSIDE : OUT_LIMIT;
            end
            S_RD_TET: ;
            S_RD_POS: begin
                r_nbr  <= nbr_q;
            end
            S_DIFF: begin
                r_d[0] <= 33'(r_vx) - 33'(signed'(px_q));
                r_d[1] <= 33'(r_vy) - 33'(signed'(py_q));
                r_d[2] <= 33'(r_vz) - 33'(signed'(pz_q));
                r_k    <= 4'd0;
                r_w[1] <= '0;
                r_w[2] <= '0;
                r_w[3] <= '0;
            end
            S_MUL: begin
                if (r_k != 4'd9) r_k <= r_k + 4'd1;
                if (r_tv) begin
                    r_w[wgt_slot(r_kt)] <= r_w[wgt_slot(r_kt)] + 56'(term);
                end
            end
            S_ACC: r_w[0] <= ONE_Q28 - r_w[1] - r_w[2] - r_w[3];
            S_EVAL: begin
                if (r_final) begin
                    r_outc <= OUT_LIMIT;
                end else if (all_in) begin
                    r_outc <= OUT_INSIDE;
                end else if (bad_nb) begin
                    r_outc <= OUT_OUTSIDE;
                end else if (pingpong) begin
                    r_outc <= OUT_PINGPONG;
                end else begin
                    r_prev     <= r_cur;
                    r_has_prev <= 1'b1;
                    r_cur      <= TW'(nb[9:0]);
                    r_steps    <= r_steps + 17'd1;
                end
            end
            S_DONE: begin
                o_outcome   <= r_outc;
                o_tet_index <= (r_outc == OUT_OUTSIDE) ? 10'd0 : 10'(r_cur);
                o_weight0   <= (r_outc == OUT_OUTSIDE) ? 32'sd0 : sat32(r_w[0]);
                o_weight1   <= (r_outc == OUT_OUTSIDE) ? 32'sd0 : sat32(r_w[1]);
                o_weight2   <= (r_outc == OUT_OUTSIDE) ? 32'sd0 : sat32(r_w[2]);
                o_weight3   <= (r_outc == OUT_OUTSIDE) ? 32'sd0 : sat32(r_w[3]);
            end
            default: ;
        endcase
    end

    a_out_only_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> r_mode == MODE_QUERY) else $error("result for non-query");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MUL |-> o_stall) else $error("accept during walk");
    a_hint_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_outcome != OUT_OUTSIDE |-> 17'(o_tet_index) < count)
        else $error("tet out of range");
endmodule

// ----- tb/sv/tetrahedral_walk_locate_tb.sv -----
// Testbench for tetrahedral_walk_locate: loads a small probe mesh, runs directed and
// random queries under several idle/stall mixes, checks every result against a predictor.
// Depends on twl_pkg and the tetrahedral_walk_locate RTL.
module tetrahedral_walk_locate_tb;
    import twl_pkg::*;

    localparam int        MESH_TETS  = 16;
    localparam int        HOLD_LIMIT = 4000000;
    localparam logic [2:0] MODE_SPARE = 3'd5;

    typedef struct {
        logic [2:0]         mode;
        logic [9:0]         idx;
        logic [1:0]         row;
        logic signed [31:0] x, y, z;
        logic signed [10:0] s [4];
    } t_item;

    typedef struct {
        logic [1:0]         outcome;
        logic [9:0]         tet;
        logic signed [31:0] w [4];
    } t_fix;

    logic i_clk, i_rst_n, i_valid, o_stall, o_valid, i_stall;
    logic [2:0] i_mode;
    logic [9:0] i_entry_index;
    logic [1:0] i_row_select;
    logic signed [31:0] i_val_x, i_val_y, i_val_z;
    logic signed [10:0] i_slot0, i_slot1, i_slot2, i_slot3;
    logic [1:0] o_outcome;
    logic [9:0] o_tet_index;
    logic signed [31:0] o_weight0, o_weight1, o_weight2, o_weight3;
    logic psel, penable, pwrite, pready;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;

    tetrahedral_walk_locate i_dut (.*);

    // predictor state
    logic signed [31:0] pos_x [1024], pos_y [1024], pos_z [1024];
    logic [9:0]         vert0 [1024];
    logic signed [10:0] nbr [1024][4];
    logic signed [31:0] coef [1024][9];
    logic [9:0]         hint;
    logic [10:0]        tet_count;
    logic signed [28:0] tolerance;
    bit                 probe_known [1024];
    int                 known_probes [$];

    t_fix pending_fixes [$];
    int   errors = 0;
    int   cycles = 0;
    int   send_idle = 0;
    int   recv_stall = 0;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > HOLD_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) i_stall <= ($urandom_range(0, 99) < recv_stall);

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_fix f;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_fixes.size() == 0) begin
                report_mismatch("unexpected result", o_tet_index, -1);
            end else begin
                f = pending_fixes.pop_front();
                if (o_outcome !== f.outcome) report_mismatch("outcome", o_outcome, f.outcome);
                if (o_tet_index !== f.tet) report_mismatch("tet_index", o_tet_index, f.tet);
                if (o_weight0 !== f.w[0]) report_mismatch("weight0", o_weight0, f.w[0]);
                if (o_weight1 !== f.w[1]) report_mismatch("weight1", o_weight1, f.w[1]);
                if (o_weight2 !== f.w[2]) report_mismatch("weight2", o_weight2, f.w[2]);
                if (o_weight3 !== f.w[3]) report_mismatch("weight3", o_weight3, f.w[3]);
            end
        end
    end

    function automatic void bary_weights(int t, longint qx, longint qy, longint qz,
                                         output longint w [4]);
        longint d [3];
        longint acc;
        d[0] = qx - longint'(pos_x[vert0[t]]);
        d[1] = qy - longint'(pos_y[vert0[t]]);
        d[2] = qz - longint'(pos_z[vert0[t]]);
        for (int r = 0; r < 3; r++) begin
            acc = 0;
            for (int c = 0; c < 3; c++) acc += (d[c] * longint'(coef[t][r*3+c])) >>> 12;
            w[r+1] = acc;
        end
        w[0] = (longint'(1) <<< 28) - w[1] - w[2] - w[3];
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic t_fix locate_point(t_item it);
        t_fix   r;
        longint w [4];
        longint worst;
        int     cnt, cur, prev, f, n;
        bit     has_prev, done;
        cnt = (tet_count > 1024) ? 1024 : int'(tet_count);
        cur = 0; prev = 0; has_prev = 0; done = 0;
        r.outcome = OUT_LIMIT;
        for (int k = 0; k < 4; k++) w[k] = 0;
        if (cnt == 0) begin
            r.outcome = OUT_OUTSIDE;
        end else begin
            cur = (int'(hint) < cnt) ? int'(hint) : 0;
            for (int st = 0; st < cnt + 1 && !done; st++) begin
                bary_weights(cur, it.x, it.y, it.z, w);
                if (w[0] >= tolerance && w[1] >= tolerance &&
                    w[2] >= tolerance && w[3] >= tolerance) begin
                    r.outcome = OUT_INSIDE; done = 1;
                end else begin
                    f = 0; worst = w[0];
                    for (int k = 1; k < 4; k++) if (w[k] < worst) begin
                        worst = w[k]; f = k;
                    end
                    n = nbr[cur][f];
                    if (n < 0 || n >= cnt) begin
                        r.outcome = OUT_OUTSIDE; done = 1;
                    end else if (has_prev && n == prev) begin
                        r.outcome = OUT_PINGPONG; done = 1;
                    end else begin
                        prev = cur; has_prev = 1; cur = n;
                    end
                end
            end
            if (!done) bary_weights(cur, it.x, it.y, it.z, w);
        end
        if (r.outcome == OUT_OUTSIDE) begin
            cur = 0;
            for (int k = 0; k < 4; k++) w[k] = 0;
        end else begin
            hint = 10'(cur);
        end
        r.tet = 10'(cur);
        for (int k = 0; k < 4; k++) r.w[k] = clip32(w[k]);
        return r;
    endfunction

    function automatic void store_load(t_item it);
        case (it.mode)
            MODE_PROBE: begin
                pos_x[it.idx] = it.x; pos_y[it.idx] = it.y; pos_z[it.idx] = it.z;
                if (!probe_known[it.idx]) known_probes.push_back(int'(it.idx));
                probe_known[it.idx] = 1;
            end
            MODE_VERT: vert0[it.idx] = it.s[0][9:0];
            MODE_NBR: for (int k = 0; k < 4; k++) nbr[it.idx][k] = it.s[k];
            MODE_ROW: if (it.row < 3) begin
                coef[it.idx][it.row*3]   = it.x;
                coef[it.idx][it.row*3+1] = it.y;
                coef[it.idx][it.row*3+2] = it.z;
            end
            default: ;
        endcase
    endfunction

    task automatic send_item(t_item it);
        while ($urandom_range(0, 99) < send_idle) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_mode <= it.mode; i_entry_index <= it.idx; i_row_select <= it.row;
        i_val_x <= it.x; i_val_y <= it.y; i_val_z <= it.z;
        i_slot0 <= it.s[0]; i_slot1 <= it.s[1]; i_slot2 <= it.s[2]; i_slot3 <= it.s[3];
        i_valid <= 1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (it.mode == MODE_QUERY) pending_fixes.push_back(locate_point(it));
        else store_load(it);
    endtask

    task automatic wait_idle();
        i_valid <= 0;
        @(posedge i_clk);
        while (pending_fixes.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (addr == {REG_COUNT, 2'b00}) tet_count = data[10:0];
        else tolerance = data[28:0];
    endtask

    task automatic set_config(logic [10:0] cnt, logic signed [28:0] tol);
        wait_idle();
        apb_write({REG_COUNT, 2'b00}, 32'(cnt));
        apb_write({REG_TOL, 2'b00}, 32'(tol));
    endtask

    function automatic t_item blank_item(logic [2:0] mode, logic [9:0] idx);
        t_item it;
        it.mode = mode; it.idx = idx; it.row = 0;
        it.x = 0; it.y = 0; it.z = 0;
        for (int k = 0; k < 4; k++) it.s[k] = 0;
        return it;
    endfunction

    function automatic logic signed [31:0] near_val();
        return $signed(32'($urandom_range(0, 1 << 18))) - (1 << 17);
    endfunction

    function automatic t_item make_query();
        t_item it;
        int p;
        it = blank_item(MODE_QUERY, 10'($urandom));
        it.row = 2'($urandom);
        for (int k = 0; k < 4; k++) it.s[k] = 11'($urandom);
        if ($urandom_range(0, 4) == 0) begin
            it.x = $urandom; it.y = $urandom; it.z = $urandom;
        end else begin
            p = known_probes[$urandom_range(0, known_probes.size() - 1)];
            it.x = pos_x[p] + near_val() / 2;
            it.y = pos_y[p] + near_val() / 2;
            it.z = pos_z[p] + near_val() / 2;
        end
        return it;
    endfunction

    // loads keep tets below MESH_TETS readable: vertex 0 on a known probe,
    // neighbours either negative or inside the mesh
    function automatic t_item make_load();
        t_item it;
        int sel;
        sel = $urandom_range(0, 19);
        it = blank_item(MODE_PROBE, ($urandom_range(0, 1)) ?
                                    10'($urandom_range(0, MESH_TETS - 1)) : 10'($urandom));
        it.row = 2'($urandom);
        it.x = $urandom; it.y = $urandom; it.z = $urandom;
        for (int k = 0; k < 4; k++) it.s[k] = 11'($urandom);
        if (sel < 5) begin
            it.mode = MODE_PROBE;
            it.x = near_val(); it.y = near_val(); it.z = near_val();
        end else if (sel < 9) begin
            it.mode = MODE_VERT;
            if (it.idx < MESH_TETS)
                it.s[0] = 11'(known_probes[$urandom_range(0, known_probes.size() - 1)]);
        end else if (sel < 13) begin
            it.mode = MODE_NBR;
            if (it.idx < MESH_TETS) for (int k = 0; k < 4; k++)
                it.s[k] = ($urandom_range(0, 2) == 0) ? -$signed(11'($urandom_range(1, 1024)))
                                                      : 11'($urandom_range(0, MESH_TETS - 1));
        end else if (sel < 19) begin
            it.mode = MODE_ROW;
            if ($urandom_range(0, 7) != 0) begin
                it.x = $signed(32'($urandom_range(0, 1 << 25))) - (1 << 24);
                it.y = $signed(32'($urandom_range(0, 1 << 25))) - (1 << 24);
                it.z = $signed(32'($urandom_range(0, 1 << 25))) - (1 << 24);
            end
        end else begin
            it.mode = MODE_SPARE + 3'($urandom_range(0, 2));
        end
        return it;
    endfunction

    task automatic test_mesh_build();
        t_item it;
        for (int p = 0; p < MESH_TETS; p++) begin
            it = blank_item(MODE_PROBE, 10'(p));
            it.x = near_val(); it.y = near_val(); it.z = near_val();
            send_item(it);
        end
        it = blank_item(MODE_PROBE, 10'd1023);
        it.x = 32'sh7fffffff; it.y = 32'sh80000000; it.z = 0;
        send_item(it);
        for (int t = 0; t < MESH_TETS; t++) begin
            it = blank_item(MODE_VERT, 10'(t));
            it.s[0] = (t == 3) ? -11'sd1 : 11'(t);
            for (int k = 1; k < 4; k++) it.s[k] = 11'($urandom_range(0, 1023));
            send_item(it);
            it = blank_item(MODE_NBR, 10'(t));
            for (int k = 0; k < 4; k++)
                it.s[k] = ($urandom_range(0, 3) == 0) ? -11'sd1
                                                      : 11'($urandom_range(0, MESH_TETS - 1));
            send_item(it);
            for (int r = 0; r < 3; r++) begin
                it = blank_item(MODE_ROW, 10'(t));
                it.row = 2'(r);
                it.x = $signed(32'($urandom_range(0, 1 << 25))) - (1 << 24);
                it.y = $signed(32'($urandom_range(0, 1 << 25))) - (1 << 24);
                it.z = $signed(32'($urandom_range(0, 1 << 25))) - (1 << 24);
                send_item(it);
            end
        end
    endtask

    task automatic test_directed();
        t_item it;
        // empty mesh: reset count is zero
        send_item(make_query());
        set_config(11'(MESH_TETS), TOL_RESET);
        it = make_query(); it.x = 32'sh7fffffff; it.y = 32'sh80000000; it.z = 32'sh7fffffff;
        send_item(it);
        it.x = 32'sh80000000; it.y = 32'sh7fffffff; it.z = 32'sh80000000;
        send_item(it);
        // ignored loads (spare modes, row 3), then loads at an index above the mesh with extreme slots
        for (int m = 0; m < 3; m++) send_item(blank_item(MODE_SPARE + 3'(m), 10'd1023));
        it = blank_item(MODE_ROW, 10'd0); it.row = 2'd3; it.x = 32'sh80000000; send_item(it);
        it = blank_item(MODE_NBR, 10'd1023);
        it.s[0] = -11'sd1024; it.s[1] = 11'sd1023; it.s[2] = -11'sd1; it.s[3] = 0;
        send_item(it);
        it = blank_item(MODE_VERT, 10'd1023);
        it.s[0] = 11'sd1023; it.s[1] = -11'sd1024; it.s[2] = -11'sd1; it.s[3] = 11'sd1;
        send_item(it);
        set_config(11'(MESH_TETS), -29'sd268435456);
        repeat (3) send_item(make_query());
        set_config(11'(MESH_TETS), 29'sd0);
        repeat (3) send_item(make_query());
        // count at and above the table depth, then a short mesh with the hint out of range
        set_config(11'd1024, TOL_RESET);
        repeat (2) send_item(make_query());
        set_config(11'd2047, 29'sd0);
        send_item(make_query());
        set_config(11'd1, TOL_RESET);
        repeat (2) send_item(make_query());
    endtask

    task automatic test_random(int n_items, int idle_pct, int stall_pct);
        int done_items, block;
        logic [10:0] cnt;
        logic signed [28:0] tol;
        t_item it;
        done_items = 0;
        wait_idle();
        send_idle = idle_pct; recv_stall = stall_pct;
        while (done_items < n_items) begin
            case ($urandom_range(0, 9))
                0: cnt = 11'd0;
                1: cnt = 11'd1;
                2: cnt = ($urandom_range(0, 1)) ? 11'd1024 : 11'($urandom_range(1025, 2047));
                default: cnt = 11'($urandom_range(2, MESH_TETS));
            endcase
            case ($urandom_range(0, 4))
                0: tol = -29'sd268435456;
                1: tol = 29'sd0;
                2: tol = TOL_RESET;
                default: tol = -$signed(29'($urandom_range(0, 1 << 27)));
            endcase
            set_config(cnt, tol);
            block = (cnt >= 1024) ? 4 : 40;
            for (int i = 0; i < block; i++) begin
                it = ($urandom_range(0, 9) < 6) ? make_query() : make_load();
                send_item(it);
                if (it.mode <= MODE_QUERY) done_items++;
            end
        end
        wait_idle();
    endtask

    initial begin
        i_rst_n = 0; i_valid = 0; i_stall = 0;
        i_mode = 0; i_entry_index = 0; i_row_select = 0;
        i_val_x = 0; i_val_y = 0; i_val_z = 0;
        i_slot0 = 0; i_slot1 = 0; i_slot2 = 0; i_slot3 = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        hint = 0; tet_count = 0; tolerance = TOL_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_mesh_build();
        test_directed();
        test_random(250, 0, 0);
        test_random(250, 68, 0);
        test_random(250, 0, 68);
        test_random(250, 19, 19);
        send_idle = 0; recv_stall = 0;
        wait_idle();
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/twl_pkg.sv
design/twl_ram.sv
design/twl_mac.sv
design/tetrahedral_walk_locate.sv
tb/sv/tetrahedral_walk_locate_tb.sv
